### hw/rtl/bhtc_pkg.sv
// Package: shared types, constants and helper functions for the button hold-time classifier.
`default_nettype none

package bhtc_pkg;

  // Width of the grace, hold and release counters
  localparam int CNT_W = 16;
  // Width of every configuration register
  localparam int CFG_W = 16;
  // Width of the configuration register index
  localparam int CFG_IDX_W = 8;
  // Compare width that covers both a counter and a threshold
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_GRACE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_PRESS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REL_DEBOUNCE = CFG_IDX_W'(3);

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] BOOT_GRACE_RST   = CFG_W'(100);
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = CFG_W'(150);
  localparam logic [CFG_W-1:0] DIAG_PRESS_RST   = CFG_W'(250);
  localparam logic [CFG_W-1:0] REL_DEBOUNCE_RST = CFG_W'(4);

  typedef struct packed {
    logic [CFG_W-1:0] boot_grace_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] diag_press_ticks;
    logic [CFG_W-1:0] release_debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] grace_count;
    logic             press_active;
    logic             long_fired;
    logic             diag_fired;
    logic [CNT_W-1:0] hold_count;
    logic             release_pending;
    logic [CNT_W-1:0] release_count;
  } state_t;

  typedef struct packed {
    logic long_press;
    logic diag_toggle;
    logic is_pressed;
    logic short_press_ended;
    logic armed;
  } res_t;

  // Saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Unsigned count >= threshold over the common compare width
  function automatic logic cnt_ge(input logic [CNT_W-1:0] cnt, input logic [CFG_W-1:0] thr);
    return CMP_W'(cnt) >= CMP_W'(thr);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bhtc_core.sv
// Classifier state registers and the single-pass next-state and result logic.
`default_nettype none

module bhtc_core
  import bhtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic pin_level,
  input  wire cfg_t cfg,
  output res_t      res
);

  state_t           st_r;
  state_t           st_nxt;
  logic [CNT_W-1:0] hold_inc;
  logic [CNT_W-1:0] rel_inc;
  logic             down;

  assign hold_inc = sat_inc(st_r.hold_count);
  assign rel_inc  = sat_inc(st_r.release_count);
  assign down     = !pin_level;

  always_comb begin
    st_nxt = st_r;
    res    = '0;
    if (!cnt_ge(st_r.grace_count, cfg.boot_grace_ticks)) begin
      // still in boot grace: drop the sample
      st_nxt.grace_count = sat_inc(st_r.grace_count);
    end else begin
      res.armed = 1'b1;
      if (down) begin
        st_nxt.release_pending = 1'b0;
        st_nxt.release_count   = '0;
        if (!st_r.press_active) begin
          st_nxt.press_active = 1'b1;
          st_nxt.long_fired   = 1'b0;
          st_nxt.diag_fired   = 1'b0;
          st_nxt.hold_count   = '0;
        end else begin
          st_nxt.hold_count = hold_inc;
          if (!st_r.long_fired && cnt_ge(hold_inc, cfg.long_press_ticks)) begin
            st_nxt.long_fired = 1'b1;
            res.long_press    = 1'b1;
          end else if (!st_r.diag_fired && cnt_ge(hold_inc, cfg.diag_press_ticks)) begin
            st_nxt.diag_fired = 1'b1;
            res.diag_toggle   = 1'b1;
          end
        end
      end else if (st_r.press_active) begin
        st_nxt.hold_count = hold_inc;
        if (!st_r.release_pending) begin
          st_nxt.release_pending = 1'b1;
          st_nxt.release_count   = '0;
        end else begin
          st_nxt.release_count = rel_inc;
          if (cnt_ge(rel_inc, cfg.release_debounce_ticks)) begin
            // release confirmed: end the press
            res.short_press_ended  = !st_r.long_fired;
            st_nxt.press_active    = 1'b0;
            st_nxt.long_fired      = 1'b0;
            st_nxt.diag_fired      = 1'b0;
            st_nxt.hold_count      = '0;
            st_nxt.release_pending = 1'b0;
            st_nxt.release_count   = '0;
          end
        end
      end
      res.is_pressed = st_nxt.press_active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bhtc_outreg.sv
// Result register with valid flag on the output side of the classifier.
`default_nettype none

module bhtc_outreg
  import bhtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  input  wire logic out_stall,
  output logic      can_load,
  output logic      out_valid,
  output res_t      res_out
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // room when empty or when the held result leaves this edge
  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

### hw/rtl/button_hold_time_classifier.sv
// Top level of the button hold-time classifier: config registers, input stage, core, result stage.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in_     | input     | in_valid / in_stall    | in_pin_level
//  out_    | output    | out_valid / out_stall  | out_long_press, out_diag_toggle,
//          |           |                        | out_is_pressed, out_short_press_ended, out_armed
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// One request per cycle is sustained while out_stall stays low.
// The path is input register -> counter increments and threshold compares -> result register.
// Reset (rst_n low, synchronous) empties both stages, clears the classifier state and loads
// the default thresholds. A stalled result holds the result register; the input register
// then holds too, and in_stall rises only when both stages are full. Config is always ready.
`default_nettype none

module button_hold_time_classifier
  import bhtc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input requests
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_pin_level,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_long_press,
  output logic                      out_diag_toggle,
  output logic                      out_is_pressed,
  output logic                      out_short_press_ended,
  output logic                      out_armed,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic s1_pin_r;
  logic s1_adv;
  logic in_acc;
  logic out_can_load;
  res_t core_res;
  res_t out_res;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_grace_ticks       <= BOOT_GRACE_RST;
      cfg_r.long_press_ticks       <= LONG_PRESS_RST;
      cfg_r.diag_press_ticks       <= DIAG_PRESS_RST;
      cfg_r.release_debounce_ticks <= REL_DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOOT_GRACE:   cfg_r.boot_grace_ticks       <= cfg_wdata;
        REG_LONG_PRESS:   cfg_r.long_press_ticks       <= cfg_wdata;
        REG_DIAG_PRESS:   cfg_r.diag_press_ticks       <= cfg_wdata;
        REG_REL_DEBOUNCE: cfg_r.release_debounce_ticks <= cfg_wdata;
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- input stage
  // Advance the held tick into the core when the result register has room.
  assign s1_adv       = s1_valid_r && out_can_load;
  assign in_stall     = s1_valid_r && !out_can_load;
  assign in_acc       = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pin_r <= in_pin_level;
    end
  end

  // ---------------------------------------------------------------- classifier
  // State commits only on the edge the tick moves into the result register.
  bhtc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .pin_level (s1_pin_r),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  // ---------------------------------------------------------------- result stage
  bhtc_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv),
    .res_in    (core_res),
    .out_stall (out_stall),
    .can_load  (out_can_load),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_long_press        = out_res.long_press;
  assign out_diag_toggle       = out_res.diag_toggle;
  assign out_is_pressed        = out_res.is_pressed;
  assign out_short_press_ended = out_res.short_press_ended;
  assign out_armed             = out_res.armed;

endmodule

`default_nettype wire

### hw/rtl/bhtc_checker.sv
// Port-level checker for the button hold-time classifier and its bind.
`default_nettype none

module bhtc_checker
  import bhtc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_long_press,
  input wire logic out_diag_toggle,
  input wire logic out_is_pressed,
  input wire logic out_short_press_ended,
  input wire logic out_armed
);

  // a reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_long_press)
      && $stable(out_diag_toggle) && $stable(out_is_pressed)
      && $stable(out_short_press_ended) && $stable(out_armed))
    else $error("stalled result changed");

  // one event per tick at most
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_long_press && out_diag_toggle))
    else $error("long press and diag toggle in one result");

  // a press end leaves no press in progress
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_press_ended |-> !out_is_pressed && !out_long_press)
    else $error("short press end with press still active");

  // nothing is reported before the grace period is over
  a_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_long_press || out_diag_toggle || out_is_pressed
      || out_short_press_ended) |-> out_armed)
    else $error("activity reported while not armed");

endmodule

bind button_hold_time_classifier bhtc_checker u_bhtc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_long_press        (out_long_press),
  .out_diag_toggle       (out_diag_toggle),
  .out_is_pressed        (out_is_pressed),
  .out_short_press_ended (out_short_press_ended),
  .out_armed             (out_armed)
);

`default_nettype wire

### verif/press_event_checker.sv
`timescale 1ns / 100ps
// Checker for the button hold-time classifier: predicts every result and compares it.
module press_event_checker
  import bhtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_pin_level,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_long_press,
  input  logic                 out_diag_toggle,
  input  logic                 out_is_pressed,
  input  logic                 out_short_press_ended,
  input  logic                 out_armed,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   outstanding
);

  cfg_t             thr;
  logic [CNT_W-1:0] grace_cnt;
  logic [CNT_W-1:0] hold_cnt;
  logic [CNT_W-1:0] rel_cnt;
  logic             pressing;
  logic             long_done;
  logic             diag_done;
  logic             releasing;
  res_t             expected_events[$];
  int               errors = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      errors++;
    end
  endtask

  // Advance the classifier by one poll tick and build the result it must produce.
  task automatic predict_press_events(input logic level, output res_t r);
    r = '0;
    if (grace_cnt < thr.boot_grace_ticks) begin
      grace_cnt = bump(grace_cnt);
      return;
    end
    if (level == 1'b0) begin
      releasing = 1'b0;
      rel_cnt   = '0;
      if (!pressing) begin
        // the start tick never fires, whatever the thresholds
        pressing  = 1'b1;
        long_done = 1'b0;
        diag_done = 1'b0;
        hold_cnt  = '0;
      end else begin
        hold_cnt = bump(hold_cnt);
        if (!long_done && hold_cnt >= thr.long_press_ticks) begin
          long_done    = 1'b1;
          r.long_press = 1'b1;
        end else if (!diag_done && hold_cnt >= thr.diag_press_ticks) begin
          diag_done     = 1'b1;
          r.diag_toggle = 1'b1;
        end
      end
    end else if (pressing) begin
      hold_cnt = bump(hold_cnt);
      if (!releasing) begin
        releasing = 1'b1;
        rel_cnt   = '0;
      end else begin
        rel_cnt = bump(rel_cnt);
        if (rel_cnt >= thr.release_debounce_ticks) begin
          r.short_press_ended = !long_done;
          pressing  = 1'b0;
          long_done = 1'b0;
          diag_done = 1'b0;
          hold_cnt  = '0;
          releasing = 1'b0;
          rel_cnt   = '0;
        end
      end
    end
    r.is_pressed = pressing;
    r.armed      = 1'b1;
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (!rst_n) begin
      thr.boot_grace_ticks       = BOOT_GRACE_RST;
      thr.long_press_ticks       = LONG_PRESS_RST;
      thr.diag_press_ticks       = DIAG_PRESS_RST;
      thr.release_debounce_ticks = REL_DEBOUNCE_RST;
      grace_cnt = '0;
      hold_cnt  = '0;
      rel_cnt   = '0;
      pressing  = 1'b0;
      long_done = 1'b0;
      diag_done = 1'b0;
      releasing = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOOT_GRACE:   thr.boot_grace_ticks       = cfg_wdata;
          REG_LONG_PRESS:   thr.long_press_ticks       = cfg_wdata;
          REG_DIAG_PRESS:   thr.diag_press_ticks       = cfg_wdata;
          REG_REL_DEBOUNCE: thr.release_debounce_ticks = cfg_wdata;
          default: ;
        endcase
      end
      // a result always belongs to an earlier request, so compare before queuing
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("long_press", want.long_press, out_long_press);
          check_field("diag_toggle", want.diag_toggle, out_diag_toggle);
          check_field("is_pressed", want.is_pressed, out_is_pressed);
          check_field("short_press_ended", want.short_press_ended, out_short_press_ended);
          check_field("armed", want.armed, out_armed);
        end
      end
      if (in_valid && !in_stall) begin
        predict_press_events(in_pin_level, want);
        expected_events.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= expected_events.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the button hold-time classifier testbench: clock, reset, stimulus and verdict.
module testbench;
  import bhtc_pkg::*;

  // Result comes through the input register and then the result register after the request is taken.
  localparam int PIPE_LATENCY    = 2;
  // Cycles without any request, result or write moving before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Length of the long receiver hold-off that fills the pipeline.
  localparam int HOLD_OFF_CYCLES = 64;
  // Active-low button levels.
  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP   = 1'b1;
  // Index that maps to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;
  localparam logic [CFG_W-1:0]     CFG_MAX   = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_pin_level = PIN_UP;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_long_press;
  logic                 out_diag_toggle;
  logic                 out_is_pressed;
  logic                 out_short_press_ended;
  logic                 out_armed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int outstanding;

  // Knobs shared between the stimulus and the stall process.
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off_req = 1'b0;
  logic hold_off_q = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   ticks_sent = 0;

  // Thresholds currently programmed, used only to shape press lengths.
  int cur_long = int'(LONG_PRESS_RST);
  int cur_diag = int'(DIAG_PRESS_RST);
  int cur_deb  = int'(REL_DEBOUNCE_RST);

  always #5 clk = ~clk;

  button_hold_time_classifier u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pin_level          (in_pin_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_long_press        (out_long_press),
    .out_diag_toggle       (out_diag_toggle),
    .out_is_pressed        (out_is_pressed),
    .out_short_press_ended (out_short_press_ended),
    .out_armed             (out_armed),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  press_event_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pin_level          (in_pin_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_long_press        (out_long_press),
    .out_diag_toggle       (out_diag_toggle),
    .out_is_pressed        (out_is_pressed),
    .out_short_press_ended (out_short_press_ended),
    .out_armed             (out_armed),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .outstanding           (outstanding)
  );

  // Receiver side: stall at the chosen rate. A rise of hold_off_req starts one long
  // hold-off, counted here, so the sender keeps offering while the pipeline fills.
  always @(posedge clk) begin
    hold_off_q <= hold_off_req;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_off_req && !hold_off_q) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any request, result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one poll tick, idling first at the sender's rate, and hold it until taken.
  // Leave in_valid high on return so back-to-back requests need no extra edge.
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait until every expected result has come, plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Present one register write and wait for it to be taken; the caller drops valid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram all thresholds with the block idle; optionally poke the unmapped index too.
  task automatic set_thresholds(input int boot, input int long_thr, input int diag_thr,
                                input int deb, input bit poke_spare);
    drain();
    if (poke_spare) write_reg(REG_SPARE, CFG_MAX);
    write_reg(REG_BOOT_GRACE, CFG_W'(boot));
    write_reg(REG_LONG_PRESS, CFG_W'(long_thr));
    write_reg(REG_DIAG_PRESS, CFG_W'(diag_thr));
    write_reg(REG_REL_DEBOUNCE, CFG_W'(deb));
    cfg_valid <= 1'b0;
    cur_long = long_thr;
    cur_diag = diag_thr;
    cur_deb  = deb;
  endtask

  // Send a list of levels packed LSB first.
  task automatic send_pattern(input int n, input logic [31:0] levels);
    for (int i = 0; i < n; i++) send_tick(levels[i]);
  endtask

  // One press: hold around the thresholds with occasional bounce, then a release
  // that is usually long enough to end the press and sometimes cut short.
  task automatic press_sequence();
    int hold_len;
    int rel_len;
    hold_len = ($urandom_range(3) == 0) ? $urandom_range(0, 3)
                                        : $urandom_range(0, cur_long + cur_diag + 3);
    send_tick(PIN_DOWN);
    repeat (hold_len) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, cur_deb + 1)) send_tick(PIN_UP);
      end
      send_tick(PIN_DOWN);
    end
    rel_len = ($urandom_range(5) == 0) ? $urandom_range(1, cur_deb + 1)
                                       : cur_deb + 1 + $urandom_range(0, 3);
    repeat (rel_len) send_tick(PIN_UP);
  endtask

  // Mostly well-formed presses, the rest raw noise on the pin.
  task automatic tick_stream(input int n_ticks);
    int target;
    target = ticks_sent + n_ticks;
    while (ticks_sent < target) begin
      if ($urandom_range(9) < 8) begin
        press_sequence();
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(logic'($urandom_range(1)));
      end
    end
  endtask

  // Random thresholds; grace is sometimes raised past the count so far to re-enter it.
  task automatic random_phase(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (2) begin
      set_thresholds(($urandom_range(3) == 0) ? $urandom_range(0, 400) : 0,
                     $urandom_range(0, 40), $urandom_range(0, 60),
                     $urandom_range(0, 6), 1'b0);
      tick_stream(90);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Default grace: the first hundred ticks are ignored whatever the pin does.
    repeat (100) send_tick(logic'($urandom_range(1)));

    // Presses on the default thresholds, with one long receiver hold-off up front.
    hold_off_req <= 1'b1;
    tick_stream(220);

    // All thresholds zero: the start tick stays quiet, long fires on the next low
    // tick and diag on the one after; release needs two high ticks. A high tick with
    // no press does nothing. Then a short press with no hold at all.
    set_thresholds(0, 0, 0, 0, 1'b1);
    send_pattern(7, 32'b0110000_1);
    send_pattern(3, 32'b110);

    // Equal thresholds share no tick; a low tick cancels a pending release.
    set_thresholds(0, 2, 2, 1, 1'b0);
    send_pattern(8, 32'b11010000);
    send_pattern(3, 32'b110);

    // Diag below long fires first.
    set_thresholds(0, 4, 1, 0, 1'b0);
    send_pattern(7, 32'b1100000);

    // Largest grace re-enters the grace period; ticks are ignored until it is lowered.
    set_thresholds(int'(CFG_MAX), 10, 20, 3, 1'b0);
    repeat (100) send_tick(logic'($urandom_range(1)));

    random_phase(0, 0);
    random_phase(75, 0);
    random_phase(0, 75);
    random_phase(24, 24);

    drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/bhtc_pkg.sv
hw/rtl/bhtc_core.sv
hw/rtl/bhtc_outreg.sv
hw/rtl/button_hold_time_classifier.sv
hw/rtl/bhtc_checker.sv
verif/press_event_checker.sv
verif/testbench.sv
